[src/qfv_pkg.sv]
package qfv_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int SPAN_BITS_DEF  = 16;

    localparam int BIG_W   = 384;
    localparam int BCNT_W  = $clog2(BIG_W + 1);
    localparam int RF_AW   = 5;
    localparam int RF_DEPTH = 1 << RF_AW;
    localparam int PC_W    = 7;
    localparam int PROG_LEN = 77;
    localparam int OUT_W   = 64;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_FEW  = 3'd1,
        ST_SING = 3'd2,
        ST_OVF  = 3'd3,
        ST_ZERO = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        OP_CLR, OP_LDT, OP_LDY, OP_LD1, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
        OP_VDIV, OP_ADDMIN, OP_CHKZ, OP_CHKN, OP_VSKIP, OP_NEXT, OP_OUT, OP_END
    } op_t;

    typedef enum logic [3:0] {
        E_IDLE, E_FETCH, E_RDB, E_EXEC, E_MUL, E_DIV, E_DIVFIN, E_WB, E_END
    } eng_state_t;

    typedef struct packed {
        op_t              opcode;
        logic [RF_AW-1:0] dst;
        logic [RF_AW-1:0] sa;
        logic [RF_AW-1:0] sb;
    } op_word_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [OUT_W-1:0] coeff_const;
        logic [OUT_W-1:0] coeff_linear;
        logic [OUT_W-1:0] coeff_square;
        logic [OUT_W-1:0] vertex_x;
    } qfv_result_t;

    localparam logic [RF_AW-1:0] R_S0  = 5'd0;
    localparam logic [RF_AW-1:0] R_S1  = 5'd1;
    localparam logic [RF_AW-1:0] R_S2  = 5'd2;
    localparam logic [RF_AW-1:0] R_S3  = 5'd3;
    localparam logic [RF_AW-1:0] R_S4  = 5'd4;
    localparam logic [RF_AW-1:0] R_B0  = 5'd5;
    localparam logic [RF_AW-1:0] R_B1  = 5'd6;
    localparam logic [RF_AW-1:0] R_B2  = 5'd7;
    localparam logic [RF_AW-1:0] R_T   = 5'd8;
    localparam logic [RF_AW-1:0] R_Y   = 5'd9;
    localparam logic [RF_AW-1:0] R_TP  = 5'd10;
    localparam logic [RF_AW-1:0] R_M1  = 5'd11;
    localparam logic [RF_AW-1:0] R_M2  = 5'd12;
    localparam logic [RF_AW-1:0] R_C00 = 5'd13;
    localparam logic [RF_AW-1:0] R_C01 = 5'd14;
    localparam logic [RF_AW-1:0] R_C02 = 5'd15;
    localparam logic [RF_AW-1:0] R_C11 = 5'd16;
    localparam logic [RF_AW-1:0] R_C12 = 5'd17;
    localparam logic [RF_AW-1:0] R_C22 = 5'd18;
    localparam logic [RF_AW-1:0] R_DET = 5'd19;
    localparam logic [RF_AW-1:0] R_N0  = 5'd20;
    localparam logic [RF_AW-1:0] R_N1  = 5'd21;
    localparam logic [RF_AW-1:0] R_N2  = 5'd22;
    localparam logic [RF_AW-1:0] R_Q   = 5'd23;

    localparam logic [RF_AW-1:0] SLOT0 = 5'd0;
    localparam logic [RF_AW-1:0] SLOT1 = 5'd1;
    localparam logic [RF_AW-1:0] SLOT2 = 5'd2;
    localparam logic [RF_AW-1:0] SLOT3 = 5'd3;

    localparam logic [PC_W-1:0] PT_START  = 7'd8;
    localparam logic [PC_W-1:0] VSKIP_LEN = 7'd4;

    function automatic op_word_t mk(input op_t o, input logic [RF_AW-1:0] d,
                                    input logic [RF_AW-1:0] a, input logic [RF_AW-1:0] b);
        op_word_t w;
        w.opcode = o;
        w.dst    = d;
        w.sa     = a;
        w.sb     = b;
        return w;
    endfunction

    function automatic op_word_t prog_word(input logic [PC_W-1:0] pc);
        op_word_t w;
        case (pc)
            7'd0:  w = mk(OP_CLR, R_S0, R_S0, R_S0);
            7'd1:  w = mk(OP_CLR, R_S1, R_S0, R_S0);
            7'd2:  w = mk(OP_CLR, R_S2, R_S0, R_S0);
            7'd3:  w = mk(OP_CLR, R_S3, R_S0, R_S0);
            7'd4:  w = mk(OP_CLR, R_S4, R_S0, R_S0);
            7'd5:  w = mk(OP_CLR, R_B0, R_S0, R_S0);
            7'd6:  w = mk(OP_CLR, R_B1, R_S0, R_S0);
            7'd7:  w = mk(OP_CLR, R_B2, R_S0, R_S0);
            7'd8:  w = mk(OP_LDT, R_T, R_T, R_T);
            7'd9:  w = mk(OP_LDY, R_Y, R_Y, R_Y);
            7'd10: w = mk(OP_LD1, R_TP, R_TP, R_TP);
            7'd11: w = mk(OP_ADD, R_S0, R_S0, R_TP);
            7'd12: w = mk(OP_ADD, R_B0, R_B0, R_Y);
            7'd13: w = mk(OP_MUL, R_TP, R_TP, R_T);
            7'd14: w = mk(OP_ADD, R_S1, R_S1, R_TP);
            7'd15: w = mk(OP_MUL, R_M1, R_TP, R_Y);
            7'd16: w = mk(OP_ADD, R_B1, R_B1, R_M1);
            7'd17: w = mk(OP_MUL, R_TP, R_TP, R_T);
            7'd18: w = mk(OP_ADD, R_S2, R_S2, R_TP);
            7'd19: w = mk(OP_MUL, R_M1, R_TP, R_Y);
            7'd20: w = mk(OP_ADD, R_B2, R_B2, R_M1);
            7'd21: w = mk(OP_MUL, R_TP, R_TP, R_T);
            7'd22: w = mk(OP_ADD, R_S3, R_S3, R_TP);
            7'd23: w = mk(OP_MUL, R_TP, R_TP, R_T);
            7'd24: w = mk(OP_ADD, R_S4, R_S4, R_TP);
            7'd25: w = mk(OP_NEXT, R_S0, R_S0, R_S0);
            7'd26: w = mk(OP_MUL, R_M1, R_S2, R_S4);
            7'd27: w = mk(OP_MUL, R_M2, R_S3, R_S3);
            7'd28: w = mk(OP_SUB, R_C00, R_M1, R_M2);
            7'd29: w = mk(OP_MUL, R_M1, R_S3, R_S2);
            7'd30: w = mk(OP_MUL, R_M2, R_S1, R_S4);
            7'd31: w = mk(OP_SUB, R_C01, R_M1, R_M2);
            7'd32: w = mk(OP_MUL, R_M1, R_S1, R_S3);
            7'd33: w = mk(OP_MUL, R_M2, R_S2, R_S2);
            7'd34: w = mk(OP_SUB, R_C02, R_M1, R_M2);
            7'd35: w = mk(OP_MUL, R_M1, R_S0, R_S4);
            7'd36: w = mk(OP_MUL, R_M2, R_S2, R_S2);
            7'd37: w = mk(OP_SUB, R_C11, R_M1, R_M2);
            7'd38: w = mk(OP_MUL, R_M1, R_S1, R_S2);
            7'd39: w = mk(OP_MUL, R_M2, R_S0, R_S3);
            7'd40: w = mk(OP_SUB, R_C12, R_M1, R_M2);
            7'd41: w = mk(OP_MUL, R_M1, R_S0, R_S2);
            7'd42: w = mk(OP_MUL, R_M2, R_S1, R_S1);
            7'd43: w = mk(OP_SUB, R_C22, R_M1, R_M2);
            7'd44: w = mk(OP_MUL, R_M1, R_S0, R_C00);
            7'd45: w = mk(OP_MUL, R_M2, R_S1, R_C01);
            7'd46: w = mk(OP_ADD, R_DET, R_M1, R_M2);
            7'd47: w = mk(OP_MUL, R_M1, R_S2, R_C02);
            7'd48: w = mk(OP_ADD, R_DET, R_DET, R_M1);
            7'd49: w = mk(OP_CHKZ, R_DET, R_DET, R_DET);
            7'd50: w = mk(OP_MUL, R_M1, R_C00, R_B0);
            7'd51: w = mk(OP_MUL, R_M2, R_C01, R_B1);
            7'd52: w = mk(OP_ADD, R_N0, R_M1, R_M2);
            7'd53: w = mk(OP_MUL, R_M1, R_C02, R_B2);
            7'd54: w = mk(OP_ADD, R_N0, R_N0, R_M1);
            7'd55: w = mk(OP_MUL, R_M1, R_C01, R_B0);
            7'd56: w = mk(OP_MUL, R_M2, R_C11, R_B1);
            7'd57: w = mk(OP_ADD, R_N1, R_M1, R_M2);
            7'd58: w = mk(OP_MUL, R_M1, R_C12, R_B2);
            7'd59: w = mk(OP_ADD, R_N1, R_N1, R_M1);
            7'd60: w = mk(OP_MUL, R_M1, R_C02, R_B0);
            7'd61: w = mk(OP_MUL, R_M2, R_C12, R_B1);
            7'd62: w = mk(OP_ADD, R_N2, R_M1, R_M2);
            7'd63: w = mk(OP_MUL, R_M1, R_C22, R_B2);
            7'd64: w = mk(OP_ADD, R_N2, R_N2, R_M1);
            7'd65: w = mk(OP_DIV, R_Q, R_N0, R_DET);
            7'd66: w = mk(OP_OUT, SLOT0, R_Q, R_Q);
            7'd67: w = mk(OP_DIV, R_Q, R_N1, R_DET);
            7'd68: w = mk(OP_OUT, SLOT1, R_Q, R_Q);
            7'd69: w = mk(OP_DIV, R_Q, R_N2, R_DET);
            7'd70: w = mk(OP_OUT, SLOT2, R_Q, R_Q);
            7'd71: w = mk(OP_CHKN, R_N2, R_N2, R_N2);
            7'd72: w = mk(OP_VSKIP, R_Q, R_Q, R_Q);
            7'd73: w = mk(OP_VDIV, R_Q, R_N1, R_N2);
            7'd74: w = mk(OP_ADDMIN, R_Q, R_Q, R_Q);
            7'd75: w = mk(OP_OUT, SLOT3, R_Q, R_Q);
            default: w = mk(OP_END, R_Q, R_Q, R_Q);
        endcase
        return w;
    endfunction

    function automatic logic [BIG_W-1:0] big_abs(input logic [BIG_W-1:0] v);
        return v[BIG_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [OUT_W-1:0] sat64(input logic [BIG_W-1:0] v);
        logic all_same;
        all_same = (v[BIG_W-1:OUT_W-1] == '0) || (v[BIG_W-1:OUT_W-1] == '1);
        if (all_same) begin
            return v[OUT_W-1:0];
        end
        return v[BIG_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

endpackage

[src/qfv_point_mem.sv]
module qfv_point_mem #(
    parameter int MAX_POINTS = qfv_pkg::MAX_POINTS_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
    input  logic [31:0]                   wr_x,
    input  logic [31:0]                   wr_y,
    input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
    output logic [31:0]                   rd_x,
    output logic [31:0]                   rd_y
);

    logic [63:0] mem [MAX_POINTS];
    logic [63:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_y, wr_x};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_x = rd_data_reg[31:0];
    assign rd_y = rd_data_reg[63:32];

endmodule

[src/qfv_solver.sv]
module qfv_solver #(
    parameter int MAX_POINTS = qfv_pkg::MAX_POINTS_DEF,
    parameter int SPAN_BITS  = qfv_pkg::SPAN_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [$clog2(MAX_POINTS+1)-1:0] point_count,
    input  logic [31:0]                     min_x,
    input  logic                            overflow,
    output logic [$clog2(MAX_POINTS)-1:0]   pt_addr,
    input  logic [31:0]                     pt_x,
    input  logic [31:0]                     pt_y,
    output qfv_pkg::qfv_result_t            result,
    input  logic                            result_ack
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int BW    = qfv_pkg::BIG_W;

    qfv_pkg::eng_state_t state_reg, state_next;
    logic [qfv_pkg::PC_W-1:0]   pc_reg, pc_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]           npts_reg, npts_next;
    logic [31:0]                min_reg, min_next;
    logic                       span_err_reg, span_err_next;
    logic                       zero_term_reg, zero_term_next;
    logic                       neg_reg, neg_next;
    logic [BW-1:0]              a_reg, a_next;
    logic [BW-1:0]              b_reg, b_next;
    logic [BW-1:0]              r_reg, r_next;
    logic [BW-1:0]              rem_reg, rem_next;
    logic [qfv_pkg::BCNT_W-1:0] cnt_reg, cnt_next;
    qfv_pkg::status_t           status_reg, status_next;
    logic [qfv_pkg::OUT_W-1:0]  out_reg [4];
    logic [qfv_pkg::OUT_W-1:0]  out_next [4];

    logic [BW-1:0]              rf_mem [qfv_pkg::RF_DEPTH];
    logic [BW-1:0]              rf_rdata_reg;
    logic [qfv_pkg::RF_AW-1:0]  rf_raddr;
    logic                       rf_we;

    qfv_pkg::op_word_t          cur_op;
    logic [31:0]                t_diff;
    logic [BW-1:0]              n_shift;
    logic [BW:0]                rem_sh;
    logic [BW:0]                rem_diff;
    logic [BW-1:0]              q_round;

    assign cur_op = qfv_pkg::prog_word(pc_reg);
    assign pt_addr = idx_reg;
    assign t_diff = pt_x - min_reg;
    assign rem_sh = {rem_reg, a_reg[BW-1]};
    assign rem_diff = rem_sh - {1'b0, b_reg};
    assign q_round = a_reg + BW'(({rem_reg, 1'b0} >= {1'b0, b_reg}) ? 1 : 0);

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[cur_op.dst] <= r_reg;
        end
        rf_rdata_reg <= rf_mem[rf_raddr];
    end

    always_comb begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        idx_next       = idx_reg;
        npts_next      = npts_reg;
        min_next       = min_reg;
        span_err_next  = span_err_reg;
        zero_term_next = zero_term_reg;
        neg_next       = neg_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        rf_raddr       = cur_op.sa;
        rf_we          = 1'b0;
        n_shift        = '0;

        case (state_reg)
            qfv_pkg::E_IDLE: begin
                if (start) begin
                    npts_next      = point_count;
                    min_next       = min_x;
                    idx_next       = '0;
                    pc_next        = '0;
                    span_err_next  = 1'b0;
                    zero_term_next = 1'b0;
                    out_next       = '{default: '0};
                    if (point_count < CNT_W'(3)) begin
                        status_next = qfv_pkg::ST_FEW;
                        state_next  = qfv_pkg::E_END;
                    end else if (overflow) begin
                        status_next = qfv_pkg::ST_OVF;
                        state_next  = qfv_pkg::E_END;
                    end else begin
                        status_next = qfv_pkg::ST_OK;
                        state_next  = qfv_pkg::E_FETCH;
                    end
                end
            end
            qfv_pkg::E_FETCH: begin
                rf_raddr   = cur_op.sa;
                state_next = qfv_pkg::E_RDB;
            end
            qfv_pkg::E_RDB: begin
                a_next     = rf_rdata_reg;
                rf_raddr   = cur_op.sb;
                state_next = qfv_pkg::E_EXEC;
            end
            qfv_pkg::E_EXEC: begin
                state_next = qfv_pkg::E_WB;
                case (cur_op.opcode)
                    qfv_pkg::OP_CLR: r_next = '0;
                    qfv_pkg::OP_LD1: r_next = BW'(1);
                    qfv_pkg::OP_LDT: begin
                        r_next = BW'(t_diff);
                        if ((t_diff >> SPAN_BITS) != 32'd0) begin
                            span_err_next = 1'b1;
                        end
                    end
                    qfv_pkg::OP_LDY: r_next = {{(BW-32){pt_y[31]}}, pt_y};
                    qfv_pkg::OP_ADD: r_next = a_reg + rf_rdata_reg;
                    qfv_pkg::OP_SUB: r_next = a_reg - rf_rdata_reg;
                    qfv_pkg::OP_ADDMIN: r_next = a_reg + BW'({min_reg, 32'h0});
                    qfv_pkg::OP_MUL: begin
                        neg_next   = a_reg[BW-1] ^ rf_rdata_reg[BW-1];
                        a_next     = qfv_pkg::big_abs(a_reg);
                        b_next     = qfv_pkg::big_abs(rf_rdata_reg);
                        r_next     = '0;
                        state_next = qfv_pkg::E_MUL;
                    end
                    qfv_pkg::OP_DIV, qfv_pkg::OP_VDIV: begin
                        if (cur_op.opcode == qfv_pkg::OP_VDIV) begin
                            n_shift = ~(a_reg << 31) + 1'b1;
                        end else begin
                            n_shift = a_reg << 16;
                        end
                        neg_next   = n_shift[BW-1] ^ rf_rdata_reg[BW-1];
                        a_next     = qfv_pkg::big_abs(n_shift);
                        b_next     = qfv_pkg::big_abs(rf_rdata_reg);
                        rem_next   = '0;
                        cnt_next   = qfv_pkg::BCNT_W'(BW);
                        state_next = qfv_pkg::E_DIV;
                    end
                    qfv_pkg::OP_CHKZ: begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = qfv_pkg::E_FETCH;
                        if (a_reg == '0) begin
                            status_next = qfv_pkg::ST_SING;
                            state_next  = qfv_pkg::E_END;
                        end
                    end
                    qfv_pkg::OP_CHKN: begin
                        zero_term_next = (a_reg == '0);
                        pc_next        = pc_reg + 1'b1;
                        state_next     = qfv_pkg::E_FETCH;
                    end
                    qfv_pkg::OP_VSKIP: begin
                        pc_next    = zero_term_reg ? pc_reg + qfv_pkg::VSKIP_LEN
                                                   : pc_reg + 1'b1;
                        state_next = qfv_pkg::E_FETCH;
                    end
                    qfv_pkg::OP_NEXT: begin
                        state_next = qfv_pkg::E_FETCH;
                        if (CNT_W'(idx_reg) + 1'b1 < npts_reg) begin
                            idx_next = idx_reg + 1'b1;
                            pc_next  = qfv_pkg::PT_START;
                        end else if (span_err_reg) begin
                            status_next = qfv_pkg::ST_OVF;
                            state_next  = qfv_pkg::E_END;
                        end else begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    qfv_pkg::OP_OUT: begin
                        out_next[cur_op.dst[1:0]] = qfv_pkg::sat64(a_reg);
                        pc_next    = pc_reg + 1'b1;
                        state_next = qfv_pkg::E_FETCH;
                    end
                    qfv_pkg::OP_END: begin
                        status_next = zero_term_reg ? qfv_pkg::ST_ZERO : qfv_pkg::ST_OK;
                        state_next  = qfv_pkg::E_END;
                    end
                    default: state_next = qfv_pkg::E_END;
                endcase
            end
            qfv_pkg::E_MUL: begin
                if (b_reg == '0) begin
                    r_next     = neg_reg ? (~r_reg + 1'b1) : r_reg;
                    state_next = qfv_pkg::E_WB;
                end else begin
                    if (b_reg[0]) begin
                        r_next = r_reg + a_reg;
                    end
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
            end
            qfv_pkg::E_DIV: begin
                if (!rem_diff[BW]) begin
                    rem_next = rem_diff[BW-1:0];
                end else begin
                    rem_next = rem_sh[BW-1:0];
                end
                a_next   = {a_reg[BW-2:0], ~rem_diff[BW]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == qfv_pkg::BCNT_W'(1)) begin
                    state_next = qfv_pkg::E_DIVFIN;
                end
            end
            qfv_pkg::E_DIVFIN: begin
                r_next     = neg_reg ? (~q_round + 1'b1) : q_round;
                state_next = qfv_pkg::E_WB;
            end
            qfv_pkg::E_WB: begin
                rf_we      = 1'b1;
                pc_next    = pc_reg + 1'b1;
                state_next = qfv_pkg::E_FETCH;
            end
            qfv_pkg::E_END: begin
                if (result_ack) begin
                    state_next = qfv_pkg::E_IDLE;
                end
            end
            default: state_next = qfv_pkg::E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qfv_pkg::E_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pc_reg        <= pc_next;
        idx_reg       <= idx_next;
        npts_reg      <= npts_next;
        min_reg       <= min_next;
        span_err_reg  <= span_err_next;
        zero_term_reg <= zero_term_next;
        neg_reg       <= neg_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        r_reg         <= r_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        status_reg    <= status_next;
        out_reg       <= out_next;
    end

    always_comb begin
        result.valid        = (state_reg == qfv_pkg::E_END);
        result.status       = status_reg;
        result.coeff_const  = out_reg[0];
        result.coeff_linear = out_reg[1];
        result.coeff_square = out_reg[2];
        result.vertex_x     = out_reg[3];
    end

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == qfv_pkg::E_DIV |-> b_reg != '0)
        else $error("divisor is zero");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == qfv_pkg::E_EXEC |-> CNT_W'(idx_reg) < npts_reg)
        else $error("point index beyond set");

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == qfv_pkg::E_FETCH |-> pc_reg < qfv_pkg::PC_W'(qfv_pkg::PROG_LEN))
        else $error("program counter out of range");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == qfv_pkg::E_IDLE)
        else $error("start while solving");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qfv_pkg::E_END && status_reg != qfv_pkg::ST_OK
         && status_reg != qfv_pkg::ST_ZERO) |-> out_reg[0] == '0 && out_reg[3] == '0)
        else $error("error result carries values");

endmodule

[src/quadratic_fit_vertex_top.sv]
// Least-squares quadratic fit with vertex.
// Input channel s_*: one point per transaction, x in ticks, y in Q16.16; s_tlast marks
// the final point of a set and starts the solve. Points load at one per cycle until
// s_tlast; s_tready then stays low until the solve finishes and its result is taken
// into the output register.
// Result channel m_*: one transaction per set, four Q32.32 values in m_tdata and the
// status code in m_tuser (0 ok, 1 too few points, 2 singular, 3 overflow, 4 zero
// quadratic term).
// All work runs on one sequencer around a 32-entry big-integer register memory with a
// shift-add multiplier and a restoring divider. Each set runs a setup pass, one
// accumulation pass per point, then 24 multiplies and up to four divides; one set is
// solved at a time. Reset clears the point count, the minimum x and the overflow flag
// and empties the output register. A stalled receiver holds the result in the output
// register; new points are still taken, and the next result waits in the solver until
// the register frees up.
module quadratic_fit_vertex_top #(
    parameter int MAX_POINTS = qfv_pkg::MAX_POINTS_DEF,
    parameter int SPAN_BITS  = qfv_pkg::SPAN_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // x_value[31:0], y_value[63:32]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata,   // coeff_const, coeff_linear, coeff_square, vertex_x
    output logic [2:0]   m_tuser    // fit_status
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      min_reg, min_next;
    logic             ovf_reg, ovf_next;
    logic             busy_reg, busy_next;
    logic             start_reg, start_next;
    logic             m_valid_reg, m_valid_next;
    logic [255:0]     m_data_reg, m_data_next;
    logic [2:0]       m_user_reg, m_user_next;

    logic             s_fire;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rd_x;
    logic [31:0]      rd_y;
    logic             res_ack;
    qfv_pkg::qfv_result_t res;

    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign wr_en    = s_fire && (count_reg < CNT_W'(MAX_POINTS));
    assign res_ack  = res.valid && (!m_valid_reg || m_tready);

    qfv_point_mem #(
        .MAX_POINTS(MAX_POINTS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_x    (s_tdata[31:0]),
        .wr_y    (s_tdata[63:32]),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    qfv_solver #(
        .MAX_POINTS(MAX_POINTS),
        .SPAN_BITS (SPAN_BITS)
    ) u_solver (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start_reg),
        .point_count (count_reg),
        .min_x       (min_reg),
        .overflow    (ovf_reg),
        .pt_addr     (rd_addr),
        .pt_x        (rd_x),
        .pt_y        (rd_y),
        .result      (res),
        .result_ack  (res_ack)
    );

    always_comb begin
        count_next   = count_reg;
        min_next     = min_reg;
        ovf_next     = ovf_reg;
        busy_next    = busy_reg;
        start_next   = 1'b0;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire) begin
            if (wr_en) begin
                count_next = count_reg + 1'b1;
                if (s_tdata[31:0] < min_reg) begin
                    min_next = s_tdata[31:0];
                end
            end else begin
                ovf_next = 1'b1;
            end
            if (s_tlast) begin
                busy_next  = 1'b1;
                start_next = 1'b1;
            end
        end
        if (res_ack) begin
            m_valid_next = 1'b1;
            m_data_next  = {res.vertex_x, res.coeff_square, res.coeff_linear,
                            res.coeff_const};
            m_user_next  = res.status;
            count_next   = '0;
            min_next     = '1;
            ovf_next     = 1'b0;
            busy_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            min_reg     <= '1;
            ovf_reg     <= 1'b0;
            busy_reg    <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            min_reg     <= min_next;
            ovf_reg     <= ovf_next;
            busy_reg    <= busy_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
